// ----- rtl/smcd_pkg.sv -----
// Package for the serial motor command decoder.
// Holds line constants, command codes and the front-to-back queue entry type.
// No dependencies.
package smcd_pkg;

  localparam int LineLength = 16;                     // position wrap, 4..256
  localparam int PosW       = $clog2(LineLength);
  localparam int HeadDepth  = 4;
  localparam int HeadIdxW   = $clog2(HeadDepth);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] LineEnd = 8'd10;
  localparam logic [7:0] ChD     = 8'h64;  // 'd'
  localparam logic [7:0] ChL     = 8'h6c;  // 'l'
  localparam logic [7:0] ChR     = 8'h72;  // 'r'
  localparam logic [7:0] ChF     = 8'h66;  // 'f'
  localparam logic [7:0] ChB     = 8'h62;  // 'b'
  localparam logic [7:0] ChS     = 8'h73;  // 's'

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LEFT_FWD,
    CMD_LEFT_BACK,
    CMD_LEFT_STOP,
    CMD_RIGHT_FWD,
    CMD_RIGHT_BACK,
    CMD_RIGHT_STOP,
    CMD_BAD
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] duty;
  } entry_t;

endpackage

// ----- rtl/smcd_if.sv -----
// Channel interfaces for the serial motor command decoder.
// smcd_rx_if carries received bytes, smcd_res_if carries motor results.
interface smcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface smcd_res_if;
  logic       valid;
  logic       ready;
  logic       left_enable;
  logic       left_forward;
  logic [7:0] left_speed;
  logic       right_enable;
  logic       right_forward;
  logic [7:0] right_speed;
  logic       line_done;
  logic       bad_command;

  modport source (output valid, output left_enable, output left_forward, output left_speed,
                  output right_enable, output right_forward, output right_speed,
                  output line_done, output bad_command, input ready);
  modport sink   (input valid, input left_enable, input left_forward, input left_speed,
                  input right_enable, input right_forward, input right_speed,
                  input line_done, input bad_command, output ready);
endinterface

// ----- rtl/smcd_front.sv -----
// Front end: keeps the line head and write position, classifies each byte.
// Depends on smcd_pkg.
module smcd_front
  import smcd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       byte_i,
  output entry_t           entry_o
);

  logic [HeadDepth-1:0][7:0] head_q, head_d;
  logic [PosW-1:0]           pos_q, pos_d;
  logic                      is_end;
  logic                      is_dl, is_dr;

  always_comb begin
    head_d = head_q;
    if (int'(pos_q) < HeadDepth) begin
      head_d[pos_q[HeadIdxW-1:0]] = byte_i;
    end
  end

  assign is_end = (byte_i == LineEnd);
  assign is_dl  = (head_d[0] == ChD) && (head_d[1] == ChL);
  assign is_dr  = (head_d[0] == ChD) && (head_d[1] == ChR);

  always_comb begin
    entry_o.duty = head_d[3];
    if (!is_end) begin
      entry_o.cmd = CMD_NONE;
    end else if (is_dl && head_d[2] == ChF) begin
      entry_o.cmd = CMD_LEFT_FWD;
    end else if (is_dl && head_d[2] == ChB) begin
      entry_o.cmd = CMD_LEFT_BACK;
    end else if (is_dl && head_d[2] == ChS) begin
      entry_o.cmd = CMD_LEFT_STOP;
    end else if (is_dr && head_d[2] == ChF) begin
      entry_o.cmd = CMD_RIGHT_FWD;
    end else if (is_dr && head_d[2] == ChB) begin
      entry_o.cmd = CMD_RIGHT_BACK;
    end else if (is_dr && head_d[2] == ChS) begin
      entry_o.cmd = CMD_RIGHT_STOP;
    end else begin
      entry_o.cmd = CMD_BAD;
    end
  end

  // Line end restarts the line; otherwise advance and wrap.
  always_comb begin
    if (is_end || pos_q == PosW'(LineLength - 1)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      pos_q  <= '0;
    end else if (take_i) begin
      head_q <= head_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// ----- rtl/smcd_queue.sv -----
// Short queue between the front and back ends.
// Depends on smcd_pkg.
module smcd_queue
  import smcd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t pop_data_o
);

  entry_t [QueueDepth-1:0] mem_q;
  logic [QPtrW-1:0]        wr_q, rd_q;
  logic [QCntW-1:0]        cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/smcd_back.sv -----
// Back end: applies decoded commands to the motor registers and holds the result.
// Depends on smcd_pkg and smcd_res_if.
module smcd_back
  import smcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  smcd_res_if.source  res_o
);

  logic       valid_q;
  logic       l_on_q, l_on_d, l_dir_q, l_dir_d;
  logic [7:0] l_duty_q, l_duty_d;
  logic       r_on_q, r_on_d, r_dir_q, r_dir_d;
  logic [7:0] r_duty_q, r_duty_d;
  logic       done_q, bad_q;

  // Take the next entry once the result register is free or being taken.
  assign pop_o = !empty_i && (!valid_q || res_o.ready);

  always_comb begin
    l_on_d   = l_on_q;
    l_dir_d  = l_dir_q;
    l_duty_d = l_duty_q;
    r_on_d   = r_on_q;
    r_dir_d  = r_dir_q;
    r_duty_d = r_duty_q;
    case (entry_i.cmd)
      CMD_LEFT_FWD: begin
        l_on_d = 1'b1; l_dir_d = 1'b1; l_duty_d = entry_i.duty;
      end
      CMD_LEFT_BACK: begin
        l_on_d = 1'b1; l_dir_d = 1'b0; l_duty_d = entry_i.duty;
      end
      CMD_LEFT_STOP: l_on_d = 1'b0;
      CMD_RIGHT_FWD: begin
        r_on_d = 1'b1; r_dir_d = 1'b1; r_duty_d = entry_i.duty;
      end
      CMD_RIGHT_BACK: begin
        r_on_d = 1'b1; r_dir_d = 1'b0; r_duty_d = entry_i.duty;
      end
      CMD_RIGHT_STOP: r_on_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      l_on_q   <= 1'b0;
      l_dir_q  <= 1'b0;
      l_duty_q <= '0;
      r_on_q   <= 1'b0;
      r_dir_q  <= 1'b0;
      r_duty_q <= '0;
      done_q   <= 1'b0;
      bad_q    <= 1'b0;
    end else if (pop_o) begin
      valid_q  <= 1'b1;
      l_on_q   <= l_on_d;
      l_dir_q  <= l_dir_d;
      l_duty_q <= l_duty_d;
      r_on_q   <= r_on_d;
      r_dir_q  <= r_dir_d;
      r_duty_q <= r_duty_d;
      done_q   <= (entry_i.cmd != CMD_NONE);
      bad_q    <= (entry_i.cmd == CMD_BAD);
    end else if (res_o.ready) begin
      valid_q  <= 1'b0;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.left_enable   = l_on_q;
  assign res_o.left_forward  = l_dir_q;
  assign res_o.left_speed    = l_duty_q;
  assign res_o.right_enable  = r_on_q;
  assign res_o.right_forward = r_dir_q;
  assign res_o.right_speed   = r_duty_q;
  assign res_o.line_done     = done_q;
  assign res_o.bad_command   = bad_q;

endmodule

// ----- rtl/serial_motor_command_decoder_core.sv -----
// Top level of the serial motor command decoder: front, queue and back ends.
// Depends on smcd_pkg, smcd_if, smcd_front, smcd_queue and smcd_back.
//
//   channel | direction | payload                                  | transaction
//   rx_i    | in        | rx_byte                                  | valid & ready
//   res_o   | out       | motor enable/forward/speed, line flags   | valid & ready
//
// One byte per cycle while the queue has room; each result is registered off the queue.
// The two-entry queue lets the front keep taking bytes while a result waits.
// Reset clears the line head, the position and all motor registers at once.
// A stalled result holds; rx_i.ready drops only when the queue is full.
module serial_motor_command_decoder_core
  import smcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  smcd_rx_if.sink    rx_i,
  smcd_res_if.source res_o
);

  entry_t front_entry, back_entry;
  logic   q_full, q_empty, q_pop, take;

  assign rx_i.ready = !q_full;
  assign take       = rx_i.valid && !q_full;

  smcd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (rx_i.rx_byte),
    .entry_o (front_entry)
  );

  smcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_data_i (front_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (back_entry)
  );

  smcd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .entry_i (back_entry),
    .pop_o   (q_pop),
    .res_o   (res_o)
  );

endmodule

// ----- rtl/smcd_checker.sv -----
// Port-level checks for the serial motor command decoder, bound to the top level.
// Depends on smcd_if through the bound top level.
module smcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       left_enable_i,
  input logic [7:0] left_speed_i,
  input logic       right_enable_i,
  input logic [7:0] right_speed_i,
  input logic       line_done_i,
  input logic       bad_command_i
);

  // A bad command only ever comes with a line end.
  a_bad_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_command_i |-> line_done_i)
    else $error("bad_command without line_done");

  // Nothing is offered while reset is held.
  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({left_enable_i, left_speed_i, right_enable_i,
                                             right_speed_i, line_done_i, bad_command_i}))
    else $error("result changed while stalled");

endmodule

bind serial_motor_command_decoder_core smcd_checker u_smcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .left_enable_i  (res_o.left_enable),
  .left_speed_i   (res_o.left_speed),
  .right_enable_i (res_o.right_enable),
  .right_speed_i  (res_o.right_speed),
  .line_done_i    (res_o.line_done),
  .bad_command_i  (res_o.bad_command)
);

// ----- tb/tb_top.sv -----
// Self-checking bench for serial_motor_command_decoder_core: drives received bytes,
// predicts the motor state and line flags per byte and checks every result in order.
// Depends on smcd_pkg, the smcd_rx_if/smcd_res_if interfaces and the decoder RTL.
module tb_top;
  import smcd_pkg::*;

  localparam int unsigned TargetBytes = 1300;
  localparam int unsigned CalmFrom    = 1150;    // no idling on either side past this
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxPrinted  = 40;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic       left_enable;
    logic       left_forward;
    logic [7:0] left_speed;
    logic       right_enable;
    logic       right_forward;
    logic [7:0] right_speed;
    logic       line_done;
    logic       bad_command;
  } motor_status_t;

  class motor_cmd_tracker;
    logic [7:0]    head [HeadDepth];
    int unsigned   pos;
    motor_status_t motors;          // line flags always held at zero here
    motor_status_t pending[$];
    int unsigned   errors, bytes_seen, lines_seen, bad_lines, results_seen;

    function new();
      foreach (head[i]) head[i] = '0;
      pos          = 0;
      motors       = '0;
      errors       = 0;
      bytes_seen   = 0;
      lines_seen   = 0;
      bad_lines    = 0;
      results_seen = 0;
    endfunction

    function cmd_e decode_head();
      if (head[0] != ChD) return CMD_BAD;
      if (head[1] == ChL) begin
        if (head[2] == ChF) return CMD_LEFT_FWD;
        if (head[2] == ChB) return CMD_LEFT_BACK;
        if (head[2] == ChS) return CMD_LEFT_STOP;
      end else if (head[1] == ChR) begin
        if (head[2] == ChF) return CMD_RIGHT_FWD;
        if (head[2] == ChB) return CMD_RIGHT_BACK;
        if (head[2] == ChS) return CMD_RIGHT_STOP;
      end
      return CMD_BAD;
    endfunction

    function void note_byte(logic [7:0] b);
      motor_status_t want;
      cmd_e          cmd;
      bytes_seen++;
      // the line end is written at its position before the decode
      if (pos < HeadDepth) head[pos] = b;
      want = motors;
      if (b == LineEnd) begin
        cmd = decode_head();
        lines_seen++;
        case (cmd)
          CMD_LEFT_FWD: begin
            motors.left_enable  = 1'b1;
            motors.left_forward = 1'b1;
            motors.left_speed   = head[3];
          end
          CMD_LEFT_BACK: begin
            motors.left_enable  = 1'b1;
            motors.left_forward = 1'b0;
            motors.left_speed   = head[3];
          end
          CMD_LEFT_STOP: motors.left_enable = 1'b0;
          CMD_RIGHT_FWD: begin
            motors.right_enable  = 1'b1;
            motors.right_forward = 1'b1;
            motors.right_speed   = head[3];
          end
          CMD_RIGHT_BACK: begin
            motors.right_enable  = 1'b1;
            motors.right_forward = 1'b0;
            motors.right_speed   = head[3];
          end
          CMD_RIGHT_STOP: motors.right_enable = 1'b0;
          default: bad_lines++;
        endcase
        want             = motors;
        want.line_done   = 1'b1;
        want.bad_command = (cmd == CMD_BAD);
        pos = 0;
      end else begin
        pos++;
      end
      if (pos >= LineLength) pos = 0;
      pending.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MaxPrinted) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
    endtask

    task check_status(motor_status_t got);
      motor_status_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending: %h", results_seen, got));
        return;
      end
      want = pending.pop_front();
      compare_field("left_enable",   8'(got.left_enable),   8'(want.left_enable));
      compare_field("left_forward",  8'(got.left_forward),  8'(want.left_forward));
      compare_field("left_speed",    got.left_speed,        want.left_speed);
      compare_field("right_enable",  8'(got.right_enable),  8'(want.right_enable));
      compare_field("right_forward", 8'(got.right_forward), 8'(want.right_forward));
      compare_field("right_speed",   got.right_speed,       want.right_speed);
      compare_field("line_done",     8'(got.line_done),     8'(want.line_done));
      compare_field("bad_command",   8'(got.bad_command),   8'(want.bad_command));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  smcd_rx_if  rx_ch ();
  smcd_res_if res_ch ();

  serial_motor_command_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  motor_cmd_tracker tracker;
  int unsigned      cycles;
  int unsigned      src_gap_pct;
  int unsigned      sink_gap_pct;
  bit               calm;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, tracker.pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [7:0] any_but_line_end();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == LineEnd) ? 8'hff : b;
  endfunction

  function automatic int unsigned pick_gap_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    tracker.note_byte(b);
  endtask

  task automatic send_line(byte_q_t bytes);
    foreach (bytes[i]) begin
      if (!calm && $urandom_range(99) < src_gap_pct) begin
        rx_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      send_byte(bytes[i]);
    end
  endtask

  // Mostly well-formed commands with random speeds; the rest broken heads, noise and
  // lines long enough to wrap the position back over the kept bytes.
  task automatic make_random_line(output byte_q_t line);
    int unsigned kind;
    logic [7:0]  op;
    line = {};
    kind = $urandom_range(99);
    op   = ($urandom_range(2) == 0) ? ChF : (($urandom_range(1) == 0) ? ChB : ChS);
    if (kind < 60) begin
      line = '{ChD, ($urandom_range(1) == 0) ? ChL : ChR, op};
      if ($urandom_range(9) != 0) line.push_back(8'($urandom_range(255)));
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 6)) line.push_back(any_but_line_end());
    end else if (kind < 75) begin
      line = '{ChD, ($urandom_range(1) == 0) ? ChL : ChR, op, 8'($urandom_range(255))};
      if ($urandom_range(1) == 0)
        line[$urandom_range(2)] = any_but_line_end();
      else
        repeat ($urandom_range(1, 4)) void'(line.pop_back());
    end else if (kind < 90) begin
      repeat ($urandom_range(0, 40)) line.push_back(any_but_line_end());
    end else begin
      // fill exactly one wrap, so the command lands at the head again
      repeat (LineLength) line.push_back(any_but_line_end());
      line.push_back(ChD);
      line.push_back(($urandom_range(1) == 0) ? ChL : ChR);
      line.push_back(op);
      line.push_back(any_but_line_end());
      if ($urandom_range(1) == 0)
        repeat ($urandom_range(1, 20)) line.push_back(any_but_line_end());
    end
    line.push_back(LineEnd);
  endtask

  task automatic drive_result_ready();
    int unsigned   hold;
    motor_status_t got;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) begin
        got = '{res_ch.left_enable, res_ch.left_forward, res_ch.left_speed,
                res_ch.right_enable, res_ch.right_forward, res_ch.right_speed,
                res_ch.line_done, res_ch.bad_command};
        tracker.check_status(got);
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(99) < sink_gap_pct) begin
        res_ch.ready <= 1'b0;
        hold = $urandom_range(9);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  endtask

  initial begin
    byte_q_t line;
    tracker       = new();
    calm          = 1'b0;
    src_gap_pct   = 0;
    sink_gap_pct  = 0;
    rst_ni        <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    res_ch.ready  <= 1'b0;
    fork
      drive_result_ready();
    join_none
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every command, left speeds at the extremes, a missing speed byte and two short lines
    send_line('{ChD, ChL, ChF, 8'hff, LineEnd});
    send_line('{ChD, ChL, ChB, 8'h00, LineEnd});
    send_line('{ChD, ChR, ChF, LineEnd});
    send_line('{ChD, ChR, ChB, 8'h7f, LineEnd});
    send_line('{ChD, ChL, ChS, LineEnd});
    send_line('{ChD, ChR, ChS, LineEnd});
    send_line('{LineEnd});
    send_line('{ChD, LineEnd});

    src_gap_pct  = 10;
    sink_gap_pct = 10;
    while (tracker.bytes_seen < TargetBytes) begin
      // vary the idling so some stretches run flat out
      if ($urandom_range(19) == 0) begin
        src_gap_pct  = pick_gap_pct();
        sink_gap_pct = pick_gap_pct();
      end
      calm = (tracker.bytes_seen >= CalmFrom);
      make_random_line(line);
      send_line(line);
    end
    rx_ch.valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.pending.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending.size()));

    $display("run covered %0d bytes in %0d lines, %0d of them bad commands",
             tracker.bytes_seen, tracker.lines_seen, tracker.bad_lines);
    $display("%0d results checked, %0d mismatches", tracker.results_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/smcd_pkg.sv
rtl/smcd_if.sv
rtl/smcd_front.sv
rtl/smcd_queue.sv
rtl/smcd_back.sv
rtl/serial_motor_command_decoder_core.sv
rtl/smcd_checker.sv
tb/tb_top.sv
